// ----- hw/rtl/fpda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 16;
  localparam int MAX_TEXT_DEF    = 32;

  localparam int FIELD_W    = 32;
  localparam int FRAC_W     = 16;  // widest fraction
  localparam int FRAC_DEPTH = 16;  // exact expansion never exceeds the fraction bit count
  localparam int FIDX_W     = 4;
  localparam int FCNT_W     = 5;
  localparam int PROD_W     = FRAC_W + 4;
  localparam int CHAR_W     = 7;
  localparam int LEN_W      = 7;
  localparam int KIDX_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [4:0] POINT_POS_LIMIT = 5'd16;
  localparam logic [4:0] POINT_POS_RST   = 5'd8;
  localparam logic [4:0] PRECISION_RST   = 5'd2;
  localparam logic [5:0] MAX_CHARS_RST   = 6'd32;
  localparam logic       SIGNED_RST      = 1'b1;
  localparam logic [LEN_W-1:0] MIN_CHARS = 7'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [3:0] DIGIT_NINE  = 4'd9;
  localparam logic [3:0] ROUND_HALF  = 4'd5;
  localparam logic [3:0] DABBLE_ADD  = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_POS   = 2'd0,
    CFG_PRECISION   = 2'd1,
    CFG_MAX_CHARS   = 2'd2,
    CFG_SIGNED_MODE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SCAN,
    ST_FRAC,
    ST_PREP,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_SIGN,
    PH_ONE,
    PH_INT,
    PH_POINT,
    PH_FRAC
  } phase_e;

  typedef struct packed {
    logic load;
    logic dabble;
    logic scan;
    logic frac;
    logic prep;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dabble_last;
    logic scan_last;
    logic frac_done;
    logic slot_free;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fpda_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fpda_in_if import fpda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fpda_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fpda_out_if import fpda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              truncated;

  modport source (output valid, output character, output last, output truncated, input ready);
  modport sink   (input valid, input character, input last, input truncated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fpda_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fpda_cfg_if import fpda_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fixed_point_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Port    Dir   Payload                            Transfer
// in_i    sink  value[31:0]                        valid & ready
// out_o   src   character[6:0], last, truncated    valid & ready
// cfg_i   sink  index[1:0], data[5:0]              valid & ready (ready tied high)
//
// One value at a time. Per value: a load, the double-dabble shifts over all
// value bits, a scan of each integral digit position, p+1 fraction digits (or,
// when p is zero, up to the fractional bit count), a prep step, then one
// character per cycle while the output is not stalled.
// Reset restores the register defaults; a stalled output holds the pointer.

module fixed_point_to_decimal_ascii import fpda_pkg::*; #(
  parameter int VALUE_WIDTH            = VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS_AFTER_POINT = MAX_DIGITS_DEF,
  parameter int MAX_TEXT_CHARS         = MAX_TEXT_DEF
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  fpda_in_if.sink     in_i,
  fpda_out_if.source  out_o,
  fpda_cfg_if.sink    cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  fpda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpda_datapath #(
    .VALUE_WIDTH            (VALUE_WIDTH),
    .MAX_DIGITS_AFTER_POINT (MAX_DIGITS_AFTER_POINT),
    .MAX_TEXT_CHARS         (MAX_TEXT_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (in_i.value),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_char_o  (out_o.character),
    .out_last_o  (out_o.last),
    .out_trunc_o (out_o.truncated)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/fpda_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpda_ctrl import fpda_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DABBLE;
      end
      ST_DABBLE: begin
        if (status_i.dabble_last) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_FRAC;
      end
      ST_FRAC: begin
        if (status_i.frac_done) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.slot_free && status_i.emit_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DABBLE: cmd_o.dabble = 1'b1;
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_FRAC:   cmd_o.frac   = 1'b1;
      ST_PREP:   cmd_o.prep   = 1'b1;
      ST_EMIT:   cmd_o.emit   = status_i.slot_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fpda_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpda_datapath import fpda_pkg::*; #(
  parameter int VALUE_WIDTH            = VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS_AFTER_POINT = MAX_DIGITS_DEF,
  parameter int MAX_TEXT_CHARS         = MAX_TEXT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  input  wire logic [FIELD_W-1:0]    in_value_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [CHAR_W-1:0]          out_char_o,
  output logic                       out_last_o,
  output logic                       out_trunc_o
);

  localparam int INT_DIGITS = (VALUE_WIDTH * 301) / 1000 + 1;
  localparam int DIG_IDX_W  = $clog2(INT_DIGITS);
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
  localparam int EXT_W      = (VALUE_WIDTH > FRAC_W) ? VALUE_WIDTH : FRAC_W;
  localparam logic [4:0]       MAX_P     = 5'(MAX_DIGITS_AFTER_POINT);
  localparam logic [LEN_W-1:0] MAX_CHARS = LEN_W'(MAX_TEXT_CHARS);

  // configuration
  logic [4:0] point_pos_q, precision_q;
  logic [5:0] max_chars_q;
  logic       signed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_pos_q <= POINT_POS_RST;
      precision_q <= PRECISION_RST;
      max_chars_q <= MAX_CHARS_RST;
      signed_q    <= SIGNED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POINT_POS:   point_pos_q <= cfg_data_i[4:0];
        CFG_PRECISION:   precision_q <= cfg_data_i[4:0];
        CFG_MAX_CHARS:   max_chars_q <= cfg_data_i;
        CFG_SIGNED_MODE: signed_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // load
  logic [VALUE_WIDTH-1:0] v_raw, mag;
  logic                   neg_in;
  logic [4:0]             f_eff, p_eff;
  logic [EXT_W-1:0]       mag_ext, fmask_ext;

  assign v_raw     = in_value_i[VALUE_WIDTH-1:0];
  assign neg_in    = signed_q & v_raw[VALUE_WIDTH-1];
  assign mag       = neg_in ? (~v_raw + 1'b1) : v_raw;
  assign f_eff     = (point_pos_q > POINT_POS_LIMIT) ? POINT_POS_LIMIT : point_pos_q;
  assign p_eff     = (precision_q > MAX_P) ? MAX_P : precision_q;
  assign mag_ext   = EXT_W'(mag);
  assign fmask_ext = (EXT_W'(1) << f_eff) - EXT_W'(1);

  logic                   neg_q;
  logic [4:0]             f_q, p_q;
  logic [VALUE_WIDTH-1:0] ip_q;
  logic [FRAC_W-1:0]      fr_q;
  logic [BIT_CNT_W-1:0]   bc_q;
  logic [3:0]             bcd_q [INT_DIGITS];
  logic [DIG_IDX_W-1:0]   si_q;
  logic                   started_q;
  logic [LEN_W-1:0]       n_int_q, n_frac_q;
  logic                   k_valid_q, k_frac_q;
  logic [KIDX_W-1:0]      k_idx_q;
  logic [FCNT_W-1:0]      j_q;
  logic                   up_q;
  logic [3:0]             fbuf_q [FRAC_DEPTH];

  // double dabble step
  logic [3:0] adj [INT_DIGITS];
  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= ROUND_HALF) ? (bcd_q[i] + DABBLE_ADD) : bcd_q[i];
    end
  end

  // scan of the integral digits, most significant first
  logic [3:0] scan_dig;
  logic       scan_st;
  assign scan_dig = bcd_q[si_q];
  assign scan_st  = started_q | (scan_dig != 4'd0) | (si_q == '0);

  // fraction times ten
  logic [PROD_W-1:0] prod, fmask_p;
  logic [3:0]        fdig;
  logic [FRAC_W-1:0] fr_next;
  logic              exact;
  assign prod    = PROD_W'({fr_q, 3'b000}) + PROD_W'({fr_q, 1'b0});
  assign fmask_p = (PROD_W'(1) << f_q) - PROD_W'(1);
  assign fdig    = 4'(prod >> f_q);
  assign fr_next = FRAC_W'(prod & fmask_p);
  assign exact   = (p_q == 5'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q    <= neg_in;
      f_q      <= f_eff;
      p_q      <= p_eff;
      ip_q     <= mag >> f_eff;
      fr_q     <= FRAC_W'(mag_ext & fmask_ext);
      bc_q     <= '0;
      si_q     <= DIG_IDX_W'(INT_DIGITS - 1);
      n_frac_q <= LEN_W'(p_eff);
      j_q      <= '0;
      up_q     <= 1'b0;
      for (int i = 0; i < INT_DIGITS; i++) bcd_q[i] <= 4'd0;
    end
    if (cmd_i.dabble) begin
      ip_q <= ip_q << 1;
      bc_q <= bc_q + 1'b1;
      bcd_q[0] <= {adj[0][2:0], ip_q[VALUE_WIDTH-1]};
      for (int i = 1; i < INT_DIGITS; i++) bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
    end
    if (cmd_i.scan) begin
      si_q <= si_q - 1'b1;
      if (scan_st && !started_q) n_int_q <= LEN_W'(si_q) + 1'b1;
    end
    if (cmd_i.frac) begin
      fr_q <= fr_next;
      if (exact || (j_q < p_q)) begin
        fbuf_q[j_q[FIDX_W-1:0]] <= fdig;
        j_q <= j_q + 1'b1;
        if (exact) n_frac_q <= LEN_W'(j_q) + 1'b1;
      end else begin
        up_q <= (fdig >= ROUND_HALF);
      end
    end
  end

  // last digit that is not a nine: where a round-up carry stops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      k_valid_q <= 1'b0;
      k_frac_q  <= 1'b0;
      k_idx_q   <= '0;
    end else if (cmd_i.load) begin
      started_q <= 1'b0;
      k_valid_q <= 1'b0;
    end else if (cmd_i.scan) begin
      started_q <= scan_st;
      if (scan_st && (scan_dig != DIGIT_NINE)) begin
        k_valid_q <= 1'b1;
        k_frac_q  <= 1'b0;
        k_idx_q   <= KIDX_W'(si_q);
      end
    end else if (cmd_i.frac && (exact || (j_q < p_q)) && (fdig != DIGIT_NINE)) begin
      k_valid_q <= 1'b1;
      k_frac_q  <= 1'b1;
      k_idx_q   <= KIDX_W'(j_q);
    end
  end

  // text length and cut
  logic [LEN_W-1:0] lu, lt, mc, limit;
  logic             fits;
  assign lu    = LEN_W'(neg_q) + n_int_q + LEN_W'(1) + n_frac_q;
  assign lt    = lu + LEN_W'(up_q & ~k_valid_q);
  assign mc    = (LEN_W'(max_chars_q) < MIN_CHARS) ? MIN_CHARS :
                 ((LEN_W'(max_chars_q) > MAX_CHARS) ? MAX_CHARS : LEN_W'(max_chars_q));
  assign limit = mc - LEN_W'(1);
  assign fits  = (lt <= limit);

  phase_e               ph_q;
  logic [DIG_IDX_W-1:0] ic_q;
  logic [FCNT_W-1:0]    jc_q;
  logic [LEN_W-1:0]     cc_q, count_q, limit_q;
  logic                 rounded_q, trunc_q, carry1_q;

  // character under the emission pointer
  logic [3:0]        raw, dig;
  logic              is_int, before_k, at_k, emit_last;
  logic [CHAR_W-1:0] char_now;
  always_comb begin
    is_int   = (ph_q == PH_INT);
    raw      = is_int ? bcd_q[ic_q] : fbuf_q[jc_q[FIDX_W-1:0]];
    before_k = is_int ? (k_frac_q || (KIDX_W'(ic_q) > k_idx_q))
                      : (k_frac_q && (KIDX_W'(jc_q) < k_idx_q));
    at_k     = is_int ? (!k_frac_q && (KIDX_W'(ic_q) == k_idx_q))
                      : (k_frac_q && (KIDX_W'(jc_q) == k_idx_q));
    dig      = raw;
    if (rounded_q) begin
      if (!k_valid_q)     dig = 4'd0;
      else if (at_k)      dig = raw + 4'd1;
      else if (!before_k) dig = 4'd0;
    end
    case (ph_q)
      PH_SIGN:  char_now = CH_MINUS;
      PH_ONE:   char_now = CH_ONE;
      PH_POINT: char_now = CH_POINT;
      PH_INT:   char_now = CH_ZERO + CHAR_W'(dig);
      PH_FRAC:  char_now = CH_ZERO + CHAR_W'(dig);
      default:  char_now = CH_ZERO;
    endcase
  end
  assign emit_last = (cc_q == count_q - LEN_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      rounded_q <= up_q & fits;
      carry1_q  <= up_q & fits & ~k_valid_q;
      trunc_q   <= ~fits;
      limit_q   <= limit;
      count_q   <= fits ? lt : ((limit < lu) ? limit : lu);
      ph_q      <= neg_q ? PH_SIGN : ((up_q & fits & ~k_valid_q) ? PH_ONE : PH_INT);
      ic_q      <= DIG_IDX_W'(n_int_q - LEN_W'(1));
      jc_q      <= '0;
      cc_q      <= '0;
    end else if (cmd_i.emit) begin
      cc_q <= cc_q + 1'b1;
      case (ph_q)
        PH_SIGN:  ph_q <= carry1_q ? PH_ONE : PH_INT;
        PH_ONE:   ph_q <= PH_INT;
        PH_INT: begin
          if (ic_q == '0) ph_q <= PH_POINT;
          else ic_q <= ic_q - 1'b1;
        end
        PH_POINT: ph_q <= PH_FRAC;
        PH_FRAC:  jc_q <= jc_q + 1'b1;
        default:  ph_q <= PH_INT;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_o  <= char_now;
      out_last_o  <= emit_last;
      out_trunc_o <= emit_last & trunc_q;
    end
  end

  assign status_o.dabble_last = (bc_q == BIT_CNT_W'(VALUE_WIDTH - 1));
  assign status_o.scan_last   = (si_q == '0);
  assign status_o.frac_done   = exact ? (fr_next == '0) : (j_q == p_q);
  assign status_o.slot_free   = ~out_valid_o | out_ready_i;
  assign status_o.emit_last   = emit_last;

  a_emit_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (cc_q < limit_q))
    else $error("more characters than the buffer allows");

  a_round_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && rounded_q && k_valid_q && at_k &&
     (ph_q == PH_INT || ph_q == PH_FRAC)) |-> (raw != DIGIT_NINE))
    else $error("carry landed on a nine");

  a_frac_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.frac |-> (fdig <= DIGIT_NINE))
    else $error("fraction digit out of range");

  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (!out_trunc_o || out_last_o))
    else $error("truncation flag off the final character");

endmodule

`default_nettype wire

// ----- tb/fpda_tb_if.sv -----
`timescale 1ns / 1ps

// The block's channel interfaces come with the RTL; this file only holds the
// character record that the scoreboard keeps.
package fpda_tb_pkg;
  import fpda_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              truncated;
  } text_char_t;
endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import fpda_pkg::*;
  import fpda_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // Register copy and text expansion kept by the scoreboard.
  class text_scoreboard;
    text_char_t  pending_chars[$];
    logic [4:0]  point_pos   = POINT_POS_RST;
    logic [4:0]  precision   = PRECISION_RST;
    logic [5:0]  max_chars   = MAX_CHARS_RST;
    logic        signed_mode = SIGNED_RST;
    int          mismatches  = 0;

    function void write_reg(cfg_idx_e idx, logic [5:0] data);
      case (idx)
        CFG_POINT_POS:   point_pos = data[4:0];
        CFG_PRECISION:   precision = data[4:0];
        CFG_MAX_CHARS:   max_chars = data;
        CFG_SIGNED_MODE: signed_mode = data[0];
        default: ;
      endcase
    endfunction

    function void note_value(logic [31:0] value);
      byte raw_text[$];
      byte rnd_text[$];
      byte int_rev[$];
      logic [63:0] mag, ip, fr, fmask;
      int f, p, lim, cnt, start, idx;
      logic neg, round_up, carry;
      text_char_t c;
      neg = signed_mode && value[31];
      mag = neg ? (64'h1_0000_0000 - {32'd0, value}) : {32'd0, value};
      f = (point_pos > 16) ? 16 : point_pos;
      p = (precision > 16) ? 16 : precision;
      fmask = (64'd1 << f) - 1;
      ip = mag >> f;
      fr = mag & fmask;
      round_up = 0;
      if (neg) raw_text.push_back("-");
      start = raw_text.size();
      do begin
        int_rev.push_front(byte'(ip % 10));
        ip = ip / 10;
      end while (ip != 0);
      foreach (int_rev[k]) raw_text.push_back(byte'("0") + int_rev[k]);
      raw_text.push_back(".");
      if (p == 0) begin
        do begin
          fr = fr * 10;
          raw_text.push_back(byte'("0") + byte'(fr >> f));
          fr = fr & fmask;
        end while (fr != 0);
      end else begin
        for (int k = 0; k < p; k++) begin
          fr = fr * 10;
          raw_text.push_back(byte'("0") + byte'(fr >> f));
          fr = fr & fmask;
        end
        round_up = ((fr * 10) >> f) >= 5;
      end
      rnd_text = raw_text;
      if (round_up) begin
        idx = rnd_text.size() - 1;
        carry = 1;
        while (carry && idx >= start) begin
          if (rnd_text[idx] == ".") idx--;
          else if (rnd_text[idx] == "9") begin
            rnd_text[idx] = "0";
            idx--;
          end else begin
            rnd_text[idx] = rnd_text[idx] + 1;
            carry = 0;
          end
        end
        if (carry) rnd_text.insert(start, "1");
      end
      lim = (max_chars < 2) ? 1 : (max_chars > 32) ? 31 : max_chars - 1;
      if (rnd_text.size() <= lim) begin
        cnt = rnd_text.size();
        for (int k = 0; k < cnt; k++) begin
          c.character = rnd_text[k][6:0];
          c.last = (k == cnt - 1);
          c.truncated = 0;
          pending_chars.push_back(c);
        end
      end else begin
        cnt = (lim < raw_text.size()) ? lim : raw_text.size();
        for (int k = 0; k < cnt; k++) begin
          c.character = raw_text[k][6:0];
          c.last = (k == cnt - 1);
          c.truncated = (k == cnt - 1);
          pending_chars.push_back(c);
        end
      end
    endfunction

    function void check_char(text_char_t got);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected character %h", got);
        return;
      end
      want = pending_chars.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected char %h last %b trunc %b, got char %h last %b trunc %b",
                   want.character, want.last, want.truncated,
                   got.character, got.last, got.truncated);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  fpda_in_if  in_ch();
  fpda_out_if out_ch();
  fpda_cfg_if cfg_ch();
  text_scoreboard sb;
  int idle_cycles = 0;

  fixed_point_to_decimal_ascii uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.value = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_POINT_POS;
    cfg_ch.data = 0;
  end

  // Output stall pattern: ready is drawn anew each cycle, mostly high, with random stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 0;
    else case ($urandom_range(0, 3))
      0: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_char('{out_ch.character, out_ch.last, out_ch.truncated});
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [5:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_ch.valid <= 0;
  endtask

  // Without keep_valid, valid drops before the next transfer.
  task automatic send_value(logic [31:0] value, bit keep_valid);
    in_ch.valid <= 1;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_value(value);
    @(negedge clk_i);
    if (!keep_valid) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
  endtask

  task automatic drain;
    while (sb.pending_chars.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_regs(int fb, int pr, int mc, int sm);
    write_reg(CFG_POINT_POS, fb[5:0]);
    write_reg(CFG_PRECISION, pr[5:0]);
    write_reg(CFG_MAX_CHARS, mc[5:0]);
    write_reg(CFG_SIGNED_MODE, sm[5:0]);
  endtask

  task automatic random_burst(int total);
    int burst, sent;
    bit keep;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < total; k++) begin
        keep = (k < burst - 1) && (sent < total - 1);
        case ($urandom_range(0, 4))
          0: send_value({$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)},
                        keep);
          1: send_value(32'($urandom_range(0, 1023)), keep);
          default: send_value($urandom, keep);
        endcase
        sent++;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Reset settings: sign, zero, extremes, rounding carry through nines.
    send_value(32'h0000_0000, 0);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'h8000_0000, 0);
    send_value(32'h7FFF_FFFF, 0);
    send_value(32'h0000_09FF, 0);
    send_value(32'hFFFF_FF80, 0);
    drain();
    // Exact expansion, widest fraction, unsigned.
    set_regs(16, 0, 32, 0);
    send_value(32'h0000_0001, 0);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'h8000_8000, 0);
    drain();
    // Out-of-range registers clamp; tiny buffer forces truncation.
    set_regs(31, 31, 0, 1);
    send_value(32'h0000_0001, 0);
    send_value(32'h8000_0000, 0);
    drain();
    set_regs(0, 1, 63, 1);
    send_value(32'h7FFF_FFFF, 0);
    send_value(32'h8000_0000, 0);
    send_value(32'd12345, 0);
    drain();
    // Trailing nines that do not round up still fit under a small limit.
    set_regs(4, 1, 5, 0);
    send_value(32'h0000_009F, 0);
    send_value(32'h0000_000F, 0);
    drain();
    set_regs(8, 3, 2, 0);
    send_value(32'h0000_0180, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_regs($urandom_range(0, 31), ph == 0 ? 0 : $urandom_range(0, 31),
               $urandom_range(0, 1) ? 32 : $urandom_range(0, 63), $urandom_range(0, 1));
      random_burst(33);
      drain();
    end
    set_regs(POINT_POS_RST, PRECISION_RST, MAX_CHARS_RST, SIGNED_RST);
    drain();
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
